// ===== sv/rf_unwrapped_timing_histogram_macros.svh =====
// ----------------------------------------------------------------------------
// rf_unwrapped_timing_histogram_macros
// assertion macros for the timing histogrammer, empty in synthesis
// ----------------------------------------------------------------------------
`ifndef RF_UNWRAPPED_TIMING_HISTOGRAM_MACROS_SVH
`define RF_UNWRAPPED_TIMING_HISTOGRAM_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define RFUTH_ASSERT_IMP(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("rfuth assertion failed");

// next-cycle implication
`define RFUTH_ASSERT_NXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("rfuth assertion failed");

`else

`define RFUTH_ASSERT_IMP(lbl, ck, rn, ante, cons)

`define RFUTH_ASSERT_NXT(lbl, ck, rn, ante, cons)

`endif

`endif

// ===== sv/rfuth_pkg.sv =====
// ----------------------------------------------------------------------------
// rfuth_pkg
// shared types and constants of the timing histogrammer
// ----------------------------------------------------------------------------
`default_nettype none

package rfuth_pkg;

	// command codes on the request port
	localparam logic [1:0] CMD_HIT      = 2'd0;
	localparam logic [1:0] CMD_RD_TIME  = 2'd1;
	localparam logic [1:0] CMD_RD_PHASE = 2'd2;

	localparam int COUNT_W    = 32;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	// widest addresses over the legal parameter range
	localparam int TADDR_W    = 22;
	localparam int PADDR_W    = 19;
	localparam int TB_W       = 16;  // internal time bin
	localparam int RR_W       = 14;  // rounded phase, holds 8192
	localparam int TIME_W     = 26;  // signed time arithmetic
	localparam int TBIN_OUT_W = 15;
	localparam int RBIN_OUT_W = 12;

	// queue between front and back
	localparam int QDEPTH     = 2;
	localparam int QPTR_W     = 1;

	typedef enum logic [1:0] {
		OP_NONE,
		OP_HIT,
		OP_RD_TIME,
		OP_RD_PHASE
	} op_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_UPDATE
	} bk_state_t;

	typedef struct packed {
		op_t                   op;
		logic [TADDR_W-1:0]    taddr;
		logic [PADDR_W-1:0]    paddr;
		logic [TBIN_OUT_W-1:0] tbin;
		logic [RBIN_OUT_W-1:0] rbin;
		logic                  rf_used;
	} item_t;

endpackage

`default_nettype wire

// ===== sv/rfuth_front.sv =====
// ----------------------------------------------------------------------------
// rfuth_front
// takes requests, works out time and phase bins, holds one classified item
// ----------------------------------------------------------------------------
`default_nettype none

module rfuth_front #(
	parameter int CHANNELS   = 64,
	parameter int TIME_BINS  = 32768,
	parameter int PHASE_BINS = 4096
) (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  accept,
	input  wire                  full,
	input  wire  [1:0]           command,
	input  wire  [5:0]           channel,
	input  wire  [23:0]          cfd_time,
	input  wire  [19:0]          stamp,
	input  wire                  rf_valid,
	input  wire  signed [17:0]   rf_phase,
	input  wire  [14:0]          bin_index,
	output logic                 push,
	output logic                 hold,
	output rfuth_pkg::item_t     item
);

	logic                              valid_s1;
	rfuth_pkg::item_t                  item_s1;
	rfuth_pkg::item_t                  cls;

	logic                              chan_ok;
	logic [12:0]                       q;
	logic [3:0]                        f;
	logic                              up;
	logic [rfuth_pkg::RR_W-1:0]        rr;
	logic [rfuth_pkg::RR_W-1:0]        r;
	logic signed [rfuth_pkg::TIME_W-1:0] raw;
	logic signed [rfuth_pkg::TIME_W-1:0] tr;
	logic [rfuth_pkg::TB_W-1:0]        tb;
	logic [rfuth_pkg::TB_W-1:0]        sel_tbin;
	logic [14:0]                       sel_rbin;
	logic                              hit;
	logic                              rf_use;

	always_comb begin
		chan_ok = {1'b0, channel} < 7'(CHANNELS);

		// phase rounding, half to even
		q  = rf_phase[16:4];
		f  = rf_phase[3:0];
		up = (f > 4'd8) || ((f == 4'd8) && q[0]);
		rr = {1'b0, q} + {{(rfuth_pkg::RR_W-1){1'b0}}, up};
		if (rf_phase[17] || (rr >= rfuth_pkg::RR_W'(PHASE_BINS))) begin
			r = rfuth_pkg::RR_W'(PHASE_BINS - 100);
		end else begin
			r = rr;
		end

		raw = $signed({2'b00, cfd_time}) - $signed({2'b00, stamp, 4'b0000});
		tr  = raw - $signed({12'b0, r}) + $signed(rfuth_pkg::TIME_W'(TIME_BINS / 2));

		priority if (!rf_valid) begin
			tb = rfuth_pkg::TB_W'(TIME_BINS - 400);
		end else if (tr < 0) begin
			tb = rfuth_pkg::TB_W'(TIME_BINS - 200);
		end else if (tr >= $signed(rfuth_pkg::TIME_W'(TIME_BINS))) begin
			tb = rfuth_pkg::TB_W'(TIME_BINS - 300);
		end else begin
			tb = tr[rfuth_pkg::TB_W-1:0];
		end

		cls.op = rfuth_pkg::OP_NONE;
		if (chan_ok) begin
			unique case (command)
				rfuth_pkg::CMD_HIT: begin
					cls.op = rfuth_pkg::OP_HIT;
				end
				rfuth_pkg::CMD_RD_TIME: begin
					if ({2'b00, bin_index} < 17'(TIME_BINS))
						cls.op = rfuth_pkg::OP_RD_TIME;
				end
				rfuth_pkg::CMD_RD_PHASE: begin
					if ({1'b0, bin_index} < 16'(PHASE_BINS))
						cls.op = rfuth_pkg::OP_RD_PHASE;
				end
				default: begin
					cls.op = rfuth_pkg::OP_NONE;
				end
			endcase
		end

		hit      = (cls.op == rfuth_pkg::OP_HIT);
		rf_use   = hit && rf_valid;
		sel_tbin = hit ? tb : {1'b0, bin_index};
		sel_rbin = hit ? {1'b0, r} : bin_index;

		if (cls.op == rfuth_pkg::OP_NONE) begin
			cls.taddr = '0;
			cls.paddr = '0;
		end else begin
			cls.taddr = rfuth_pkg::TADDR_W'(channel) * rfuth_pkg::TADDR_W'(TIME_BINS)
				+ rfuth_pkg::TADDR_W'(sel_tbin);
			cls.paddr = rfuth_pkg::PADDR_W'(channel) * rfuth_pkg::PADDR_W'(PHASE_BINS)
				+ rfuth_pkg::PADDR_W'(sel_rbin);
		end
		cls.tbin    = hit ? tb[rfuth_pkg::TBIN_OUT_W-1:0] : '0;
		cls.rbin    = rf_use ? r[rfuth_pkg::RBIN_OUT_W-1:0] : '0;
		cls.rf_used = rf_use;
	end

	assign push = valid_s1 && !full;
	assign hold = valid_s1 && full;
	assign item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept)
			item_s1 <= cls;
	end

endmodule

`default_nettype wire

// ===== sv/rfuth_queue.sv =====
// ----------------------------------------------------------------------------
// rfuth_queue
// short fifo of classified items between front and back
// ----------------------------------------------------------------------------
`default_nettype none

module rfuth_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  wire rfuth_pkg::item_t item_in,
	input  wire                pop,
	output rfuth_pkg::item_t   item_out,
	output logic               full,
	output logic               empty
);

	rfuth_pkg::item_t                  entry_q [rfuth_pkg::QDEPTH];
	logic [rfuth_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [rfuth_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [rfuth_pkg::QPTR_W:0]        cnt_q;

	assign full     = (cnt_q == (rfuth_pkg::QPTR_W + 1)'(rfuth_pkg::QDEPTH));
	assign empty    = (cnt_q == '0);
	assign item_out = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			// depth is a power of two, pointers wrap on their own
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			unique case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= item_in;
	end

endmodule

`default_nettype wire

// ===== sv/rfuth_back.sv =====
// ----------------------------------------------------------------------------
// rfuth_back
// histogram memories, clearing pass and read-modify-write of counts
// ----------------------------------------------------------------------------
`default_nettype none

module rfuth_back #(
	parameter int CHANNELS   = 64,
	parameter int TIME_BINS  = 32768,
	parameter int PHASE_BINS = 4096
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  empty,
	input  wire rfuth_pkg::item_t                head,
	output logic                                 pop,
	output logic                                 clearing,
	output logic                                 done,
	output logic [rfuth_pkg::COUNT_W-1:0]        count,
	output logic [rfuth_pkg::TBIN_OUT_W-1:0]     time_bin,
	output logic [rfuth_pkg::RBIN_OUT_W-1:0]     rf_bin,
	output logic                                 rf_used
);

	localparam int TDEPTH = CHANNELS * TIME_BINS;
	localparam int PDEPTH = CHANNELS * PHASE_BINS;
	localparam int CDEPTH = (TDEPTH > PDEPTH) ? TDEPTH : PDEPTH;
	localparam int TA_W   = $clog2(TDEPTH);
	localparam int PA_W   = $clog2(PDEPTH);
	localparam int CL_W   = $clog2(CDEPTH);

	logic [rfuth_pkg::COUNT_W-1:0] tmem [TDEPTH];
	logic [rfuth_pkg::COUNT_W-1:0] pmem [PDEPTH];

	rfuth_pkg::bk_state_t            state_q;
	rfuth_pkg::bk_state_t            state_nxt;
	logic [CL_W-1:0]                 clr_q;
	rfuth_pkg::item_t                cur_q;
	logic [rfuth_pkg::COUNT_W-1:0]   tdat_q;
	logic [rfuth_pkg::COUNT_W-1:0]   pdat_q;
	logic                            upd;
	logic                            clear_last;

	logic                            t_we;
	logic [TA_W-1:0]                 t_wa;
	logic [rfuth_pkg::COUNT_W-1:0]   t_wd;
	logic                            p_we;
	logic [PA_W-1:0]                 p_wa;
	logic [rfuth_pkg::COUNT_W-1:0]   p_wd;
	logic [rfuth_pkg::COUNT_W-1:0]   t_inc;
	logic [rfuth_pkg::COUNT_W-1:0]   p_inc;
	logic [rfuth_pkg::COUNT_W-1:0]   res_cnt;

	logic                            done_q;
	logic [rfuth_pkg::COUNT_W-1:0]   count_q;
	logic [rfuth_pkg::TBIN_OUT_W-1:0] tbin_q;
	logic [rfuth_pkg::RBIN_OUT_W-1:0] rbin_q;
	logic                            rf_used_q;

	assign clear_last = (clr_q == CL_W'(CDEPTH - 1));

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			rfuth_pkg::BK_CLEAR:  if (clear_last) state_nxt = rfuth_pkg::BK_IDLE;
			rfuth_pkg::BK_IDLE:   if (!empty) state_nxt = rfuth_pkg::BK_UPDATE;
			rfuth_pkg::BK_UPDATE: state_nxt = rfuth_pkg::BK_IDLE;
			default:              state_nxt = rfuth_pkg::BK_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		clearing = 1'b0;
		pop      = 1'b0;
		upd      = 1'b0;
		unique case (state_q)
			rfuth_pkg::BK_CLEAR:  clearing = 1'b1;
			rfuth_pkg::BK_IDLE:   pop = !empty;
			rfuth_pkg::BK_UPDATE: upd = 1'b1;
			default:              clearing = 1'b1;
		endcase
	end

	// saturating increments and write ports
	always_comb begin
		t_inc = (tdat_q == rfuth_pkg::COUNT_MAX) ? tdat_q : tdat_q + 1'b1;
		p_inc = (pdat_q == rfuth_pkg::COUNT_MAX) ? pdat_q : pdat_q + 1'b1;

		if (clearing) begin
			t_we = {1'b0, clr_q} < (CL_W + 1)'(TDEPTH);
			t_wa = clr_q[TA_W-1:0];
			t_wd = '0;
			p_we = {1'b0, clr_q} < (CL_W + 1)'(PDEPTH);
			p_wa = clr_q[PA_W-1:0];
			p_wd = '0;
		end else begin
			t_we = upd && (cur_q.op == rfuth_pkg::OP_HIT);
			t_wa = cur_q.taddr[TA_W-1:0];
			t_wd = t_inc;
			p_we = upd && (cur_q.op == rfuth_pkg::OP_HIT) && cur_q.rf_used;
			p_wa = cur_q.paddr[PA_W-1:0];
			p_wd = p_inc;
		end

		unique case (cur_q.op)
			rfuth_pkg::OP_HIT:      res_cnt = t_inc;
			rfuth_pkg::OP_RD_TIME:  res_cnt = tdat_q;
			rfuth_pkg::OP_RD_PHASE: res_cnt = pdat_q;
			default:                res_cnt = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rfuth_pkg::BK_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (clearing)
				clr_q <= clr_q + 1'b1;
			done_q <= upd;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			cur_q <= head;
		if (upd) begin
			count_q   <= res_cnt;
			tbin_q    <= cur_q.tbin;
			rbin_q    <= cur_q.rbin;
			rf_used_q <= cur_q.rf_used;
		end
	end

	// time histogram memory
	always_ff @(posedge clk) begin
		if (t_we)
			tmem[t_wa] <= t_wd;
		if (pop)
			tdat_q <= tmem[head.taddr[TA_W-1:0]];
	end

	// phase histogram memory
	always_ff @(posedge clk) begin
		if (p_we)
			pmem[p_wa] <= p_wd;
		if (pop)
			pdat_q <= pmem[head.paddr[PA_W-1:0]];
	end

	assign done     = done_q;
	assign count    = count_q;
	assign time_bin = tbin_q;
	assign rf_bin   = rbin_q;
	assign rf_used  = rf_used_q;

endmodule

`default_nettype wire

// ===== sv/rf_unwrapped_timing_histogram.sv =====
// ----------------------------------------------------------------------------
// rf_unwrapped_timing_histogram
// per-channel timing and rf phase histograms with bin readback
// ----------------------------------------------------------------------------
// A request is taken on a clock edge with start high and busy low. Every
// request gives exactly one result, shown for a single cycle with done high;
// the receiver cannot stall, so it must take the result in that cycle. The
// back end handles one request at a time in two steps: it pops the request
// and reads both histogram memories, then writes the incremented count and
// registers the result; it takes no new request until it is through with the
// last, while the front stage and a two-entry queue absorb short bursts.
// After reset busy stays high during the clearing pass, which writes zero to
// every entry of both histogram memories.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rf_unwrapped_timing_histogram_macros.svh"

module rf_unwrapped_timing_histogram #(
	parameter int CHANNELS   = 64,
	parameter int TIME_BINS  = 32768,
	parameter int PHASE_BINS = 4096
) (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  start,
	output logic                                 busy,
	input  wire  [1:0]                           command,
	input  wire  [5:0]                           channel,
	input  wire  [23:0]                          cfd_time,
	input  wire  [19:0]                          stamp,
	input  wire                                  rf_valid,
	input  wire  signed [17:0]                   rf_phase,
	input  wire  [14:0]                          bin_index,
	output logic                                 done,
	output logic [rfuth_pkg::COUNT_W-1:0]        count,
	output logic [rfuth_pkg::TBIN_OUT_W-1:0]     time_bin,
	output logic [rfuth_pkg::RBIN_OUT_W-1:0]     rf_bin,
	output logic                                 rf_used
);

	// request handshake
	logic             accept;
	logic             hold;
	logic             clearing;

	// front to queue
	logic             push;
	rfuth_pkg::item_t front_item;
	logic             q_full;

	// queue to back
	logic             pop;
	logic             q_empty;
	rfuth_pkg::item_t head_item;

	// busy while the memories are being cleared, or while the front stage
	// holds an item the full queue cannot yet take
	assign busy   = clearing || hold;
	assign accept = start && !busy;

	// front: bin arithmetic (phase rounding, clamps, marker bins) and
	// address generation, registered into one holding stage
	rfuth_front #(
		.CHANNELS   (CHANNELS),
		.TIME_BINS  (TIME_BINS),
		.PHASE_BINS (PHASE_BINS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.full      (q_full),
		.command   (command),
		.channel   (channel),
		.cfd_time  (cfd_time),
		.stamp     (stamp),
		.rf_valid  (rf_valid),
		.rf_phase  (rf_phase),
		.bin_index (bin_index),
		.push      (push),
		.hold      (hold),
		.item      (front_item)
	);

	// decoupling queue, keeps request order
	rfuth_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.item_in  (front_item),
		.pop      (pop),
		.item_out (head_item),
		.full     (q_full),
		.empty    (q_empty)
	);

	// back: memories, clearing pass, saturating count update, result register
	rfuth_back #(
		.CHANNELS   (CHANNELS),
		.TIME_BINS  (TIME_BINS),
		.PHASE_BINS (PHASE_BINS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.empty    (q_empty),
		.head     (head_item),
		.pop      (pop),
		.clearing (clearing),
		.done     (done),
		.count    (count),
		.time_bin (time_bin),
		.rf_bin   (rf_bin),
		.rf_used  (rf_used)
	);

	// back end never produces results on adjacent cycles
	`RFUTH_ASSERT_NXT(a_done_spacing, clk, arst_n, done, !done)
	// a hit that counted a phase also counted its time bin
	`RFUTH_ASSERT_IMP(a_hit_counts, clk, arst_n, done && rf_used, count != '0)
	// phase bin is only reported for hits that used the rf phase
	`RFUTH_ASSERT_IMP(a_rf_bin_zero, clk, arst_n, done && !rf_used, rf_bin == '0)
	// no result while the clearing pass runs
	`RFUTH_ASSERT_IMP(a_quiet_clear, clk, arst_n, clearing, !done)

endmodule

`default_nettype wire
